### design/rht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rht_pkg;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_REPLAY    = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;

   // One table entry as it is held in the entry memory.
   typedef struct packed {
      logic [63:0] session_hi;
      logic [63:0] session_lo;
      logic [63:0] node_id;
      logic [63:0] high_water;
      logic [63:0] stamp;
   } rht_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request and rewind the scan
      logic scan_en;   // step the table scan
      logic commit;    // apply the outcome and load the response register
   } rht_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done; // every used entry has been read and examined
      logic rsp_free;  // the response register can take a new result
   } rht_sts_type;

endpackage

`default_nettype wire

### design/rht_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rht_datapath #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rht_pkg::rht_cmd_type cmd,
   output rht_pkg::rht_sts_type    sts,
   input  wire logic [63:0]        req_session_hi,
   input  wire logic [63:0]        req_session_lo,
   input  wire logic [63:0]        req_node_id,
   input  wire logic [63:0]        req_seq_num,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic                    rsp_new_entry,
   output logic                    rsp_evicted,
   output logic [5:0]              rsp_slot
);
   import rht_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   // Entry storage: one write port, one registered read port.
   rht_entry_type entry_mem [TABLE_ENTRIES];

   // Captured request.
   logic [63:0] req_hi_ff, req_lo_ff, req_node_ff, req_seq_ff;

   // Table occupancy and touch clock.
   logic [CNT_W-1:0] used_ff, used_in;
   logic [63:0]      tick_ff, tick_in;

   // Scan pipeline.
   logic [CNT_W-1:0] rd_addr_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   rht_entry_type    rd_data_ff;
   logic             rd_issue;

   // Scan results: first key match and oldest entry of another session.
   logic             match_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic [63:0]      match_seq_ff;
   logic             victim_ff;
   logic [IDX_W-1:0] victim_idx_ff;
   logic [63:0]      victim_stamp_ff;
   logic             key_eq, sess_eq, take_victim;

   // Outcome of the commit.
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   rht_entry_type    wr_data;
   logic [1:0]       status_in;
   logic             new_in, evict_in;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W+5:0] slot_wide;

   // Response register.
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic             rsp_new_ff, rsp_evict_ff;
   logic [5:0]       rsp_slot_ff;

   // Read the next used entry while the scan runs.
   assign rd_issue = cmd.scan_en && (rd_addr_ff < used_ff);

   assign sts.scan_done = !rd_issue && !rd_valid_ff;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Compare the entry read in the previous cycle against the request.
   assign sess_eq = (rd_data_ff.session_hi == req_hi_ff) &&
                    (rd_data_ff.session_lo == req_lo_ff);
   assign key_eq  = sess_eq && (rd_data_ff.node_id == req_node_ff);
   assign take_victim = rd_valid_ff && !sess_eq &&
                        (!victim_ff || (rd_data_ff.stamp < victim_stamp_ff));

   // Decide what the request does to the table once the scan is over.
   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = match_idx_ff;
      status_in = ST_OK;
      new_in    = 1'b0;
      evict_in  = 1'b0;
      slot_idx  = '0;
      used_in   = used_ff;
      tick_in   = tick_ff;
      if (match_ff) begin
         if (req_seq_ff <= match_seq_ff) begin
            status_in = ST_REPLAY;
         end else begin
            wr_en    = 1'b1;
            wr_idx   = match_idx_ff;
            slot_idx = match_idx_ff;
         end
      end else if (used_ff != FULL_COUNT) begin
         wr_en    = 1'b1;
         wr_idx   = used_ff[IDX_W-1:0];
         slot_idx = used_ff[IDX_W-1:0];
         new_in   = 1'b1;
         if (cmd.commit) begin
            used_in = used_ff + 1'b1;
         end
      end else if (victim_ff) begin
         wr_en    = 1'b1;
         wr_idx   = victim_idx_ff;
         slot_idx = victim_idx_ff;
         new_in   = 1'b1;
         evict_in = 1'b1;
      end else begin
         status_in = ST_EXHAUSTED;
      end
      if (cmd.commit && wr_en) begin
         tick_in = tick_ff + 64'd1;
      end
      wr_en = wr_en && cmd.commit;
   end

   assign wr_data.session_hi = req_hi_ff;
   assign wr_data.session_lo = req_lo_ff;
   assign wr_data.node_id    = req_node_ff;
   assign wr_data.high_water = req_seq_ff;
   assign wr_data.stamp      = tick_ff + 64'd1;

   assign slot_wide = {6'd0, slot_idx};

   // Entry memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_data;
      end
      if (rd_issue) begin
         rd_data_ff <= entry_mem[rd_addr_ff[IDX_W-1:0]];
      end
   end

   // Request capture and scan bookkeeping.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_hi_ff   <= req_session_hi;
         req_lo_ff   <= req_session_lo;
         req_node_ff <= req_node_id;
         req_seq_ff  <= req_seq_num;
      end
      if (rd_issue) begin
         rd_idx_ff <= rd_addr_ff[IDX_W-1:0];
      end
      if (rd_valid_ff && key_eq && !match_ff) begin
         match_idx_ff <= rd_idx_ff;
         match_seq_ff <= rd_data_ff.high_water;
      end
      if (take_victim) begin
         victim_idx_ff   <= rd_idx_ff;
         victim_stamp_ff <= rd_data_ff.stamp;
      end
   end

   // Control state of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         tick_ff      <= '0;
         rd_addr_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         match_ff     <= 1'b0;
         victim_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         tick_ff <= tick_in;
         if (cmd.capture) begin
            rd_addr_ff  <= '0;
            rd_valid_ff <= 1'b0;
            match_ff    <= 1'b0;
            victim_ff   <= 1'b0;
         end else begin
            if (rd_issue) begin
               rd_addr_ff <= rd_addr_ff + 1'b1;
            end
            rd_valid_ff <= rd_issue;
            if (rd_valid_ff && key_eq) begin
               match_ff <= 1'b1;
            end
            if (take_victim) begin
               victim_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_new_ff    <= new_in;
         rsp_evict_ff  <= evict_in;
         rsp_slot_ff   <= slot_wide[5:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_new_entry = rsp_new_ff;
   assign rsp_evicted   = rsp_evict_ff;
   assign rsp_slot      = rsp_slot_ff;

endmodule

`default_nettype wire

### design/rht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rht_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output rht_pkg::rht_cmd_type      cmd,
   input  wire rht_pkg::rht_sts_type sts
);
   import rht_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   // Commands follow directly from the state and the status.
   assign cmd.capture = req_valid && ready_ff;
   assign cmd.scan_en = (state_ff == S_SCAN);
   assign cmd.commit  = (state_ff == S_SCAN) && sts.scan_done && sts.rsp_free;

   assign req_ready = ready_ff;

   // State and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= S_SCAN;
                  ready_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               if (sts.scan_done && sts.rsp_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### design/replay_highwater_table.sv
// Anti-replay high-water table with least-recently-touched eviction.
//
// Requests carry a session id (two 64-bit halves), a node id and a
// sequence number on req_*; each request produces exactly one response on
// rsp_* with a status (accepted, replay, store exhausted), a new-entry flag,
// an eviction flag and the slot that was written. Both sides use a
// valid/ready handshake.
//
// Each request scans the used entries of the table one per cycle through
// a single registered memory read port. A new request is accepted only
// once the previous one has finished its scan and loaded its result into
// the output register.
//
// Reset empties the table and clears the touch clock; no memory clearing
// pass is needed, since only entries below the fill count are ever read.
// When the receiver stalls, the response waits in its output register and
// the next request can still be accepted and scanned; its result is held
// back until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module replay_highwater_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_session_hi,
   input  wire logic [63:0] req_session_lo,
   input  wire logic [63:0] req_node_id,
   input  wire logic [63:0] req_seq_num,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_new_entry,
   output logic             rsp_evicted,
   output logic [5:0]       rsp_slot
);
   import rht_pkg::*;

   rht_cmd_type cmd;
   rht_sts_type sts;

   // Sequencer for one request at a time.
   rht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Entry memory, scan and response register.
   rht_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_session_hi (req_session_hi),
      .req_session_lo (req_session_lo),
      .req_node_id    (req_node_id),
      .req_seq_num    (req_seq_num),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_new_entry  (rsp_new_entry),
      .rsp_evicted    (rsp_evicted),
      .rsp_slot       (rsp_slot)
   );

   // An accepted request makes the block busy in the cycle after acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous request still in work");

   // A result is only produced at the end of a scan, which frees the input.
   a_commit_frees_input: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (req_ready && rsp_valid))
      else $error("commit did not return to idle with a valid response");

   // An eviction always places a new entry.
   a_evict_is_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (rsp_new_entry && (rsp_status == ST_OK)))
      else $error("eviction reported without a new accepted entry");

   // Rejected requests report no slot and no table change.
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
         (!rsp_new_entry && !rsp_evicted && (rsp_slot == 6'd0)))
      else $error("rejected request reported a table change");

endmodule

`default_nettype wire
